@@ design/ham_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ham_pkg
// Shared types, constants and the header match step for the header activity
// monitor.
// ----------------------------------------------------------------------------
package ham_pkg;

    // header storage and match position
    localparam int HEADER_BYTES = 8;
    localparam int HDR_W        = 64;
    localparam int LEN_W        = 4;
    localparam int POS_W        = 3;
    localparam int BYTE_W       = 8;

    // age and timeout
    localparam int TIMEOUT_W     = 16;
    localparam int AGE_WIDTH_DEF = 16;

    // configuration port
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 6;
    localparam int REG_IDX_LO = 3;

    // register reset values
    localparam logic             ENABLE_RST      = 1'b1;
    localparam logic [HDR_W-1:0] HEADER_RST      = '0;
    localparam logic [LEN_W-1:0] FIRST_LEN_RST   = 4'd1;
    localparam logic [LEN_W-1:0] SECOND_LEN_RST  = 4'd0;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd1000;

    // register indexes (address bits above the 8-byte slot)
    typedef enum logic [2:0] {
        REG_ENABLE     = 3'd0,
        REG_FIRST_HDR  = 3'd1,
        REG_FIRST_LEN  = 3'd2,
        REG_SECOND_HDR = 3'd3,
        REG_SECOND_LEN = 3'd4,
        REG_TIMEOUT    = 3'd5
    } reg_index_t;

    // request kinds
    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } opcode_t;

    // outcome of feeding one byte to one header matcher
    typedef struct packed {
        logic             done;
        logic [POS_W-1:0] pos;
    } feed_t;

    // one byte against one header: next position and completion
    function automatic feed_t ham_feed(
        input logic [HDR_W-1:0]  hdr,
        input logic [LEN_W-1:0]  len_reg,
        input logic [POS_W-1:0]  pos,
        input logic [BYTE_W-1:0] b
    );
        logic [LEN_W-1:0]  len_eff;
        logic [POS_W-1:0]  p;
        logic [LEN_W-1:0]  p_inc;
        logic [BYTE_W-1:0] ch;
        feed_t             r;
        len_eff = (len_reg > LEN_W'(HEADER_BYTES)) ? LEN_W'(HEADER_BYTES) : len_reg;
        p       = '0;
        p_inc   = '0;
        ch      = '0;
        r.done  = 1'b0;
        r.pos   = '0;
        if (len_eff != '0)
        begin
            // a stale position past the length restarts at zero
            p  = ({1'b0, pos} >= len_eff) ? '0 : pos;
            ch = hdr[{p, 3'b000} +: BYTE_W];
            if (b == ch)
            begin
                p_inc = {1'b0, p} + LEN_W'(1);
                if (p_inc >= len_eff)
                begin
                    r.done = 1'b1;
                end
                else
                begin
                    r.pos = p_inc[POS_W-1:0];
                end
            end
            else
            begin
                r.pos = (b == hdr[BYTE_W-1:0]) ? POS_W'(1) : '0;
            end
        end
        return r;
    endfunction

endpackage

@@ design/ham_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ham_in_if
// Request channel: a received byte or a time tick, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ham_in_if;
    logic                       valid;
    logic                       ready;
    logic                       opcode;
    logic [ham_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output opcode, output rx_byte, input ready);
    modport sink (input valid, input opcode, input rx_byte, output ready);
endinterface

@@ design/ham_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ham_out_if
// Result channel: activity status per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ham_out_if;
    logic valid;
    logic ready;
    logic signal_active;
    logic header_hit;
    logic timeout_event;

    modport source (output valid, output signal_active, output header_hit,
                    output timeout_event, input ready);
    modport sink (input valid, input signal_active, input header_hit,
                  input timeout_event, output ready);
endinterface

@@ design/header_activity_monitor_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// header_activity_monitor_unit
// Watches a received byte stream for two header strings and tracks whether
// a header was seen within a tick timeout.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one request per handshake: a received byte (opcode byte)
//   or one time tick (opcode tick). out_ch returns exactly one result per
//   request, in order: signal_active, header_hit, timeout_event.
//   The result is in the output register the cycle after the request is
//   taken. Throughput is one request per cycle while the receiver takes
//   results; the match, age and flag update for a request is one pass of
//   logic between the request handshake and the output register.
//   When the receiver stalls, the output register holds its result and
//   in_ch.ready stays high only if that result is taken in the same cycle.
//   Registers are written over the APB port, 8-byte slots, index in
//   paddr[5:3]; writes are expected only while no request is in flight.
//   Writing the enable register clears the active flag and the age.
//   Reset: enable on, both headers zero, first length 1, second length 0,
//   timeout 1000 ticks, match positions, flag and age cleared, output empty.
// ----------------------------------------------------------------------------
module header_activity_monitor_unit #(
    parameter int AGE_WIDTH = ham_pkg::AGE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    ham_in_if.sink                         in_ch,
    ham_out_if.source                      out_ch,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ham_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ham_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ham_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    localparam int CMP_W = (AGE_WIDTH > ham_pkg::TIMEOUT_W) ? AGE_WIDTH : ham_pkg::TIMEOUT_W;
    localparam logic [AGE_WIDTH-1:0] AGE_MAX = {AGE_WIDTH{1'b1}};

    // configuration registers
    logic                             enable_reg;
    logic [ham_pkg::HDR_W-1:0]        first_hdr_reg;
    logic [ham_pkg::LEN_W-1:0]        first_len_reg;
    logic [ham_pkg::HDR_W-1:0]        second_hdr_reg;
    logic [ham_pkg::LEN_W-1:0]        second_len_reg;
    logic [ham_pkg::TIMEOUT_W-1:0]    timeout_reg;

    // monitor state
    logic [ham_pkg::POS_W-1:0] first_pos_reg, first_pos_next;
    logic [ham_pkg::POS_W-1:0] second_pos_reg, second_pos_next;
    logic                      valid_flag_reg, valid_flag_next;
    logic [AGE_WIDTH-1:0]      age_reg, age_next;

    // output register
    logic out_valid_reg;
    logic active_reg, active_next;
    logic hit_reg, hit_next;
    logic tev_reg, tev_next;

    logic                          cfg_wr;
    logic [2:0]                    cfg_idx;
    logic                          in_take;
    logic [ham_pkg::TIMEOUT_W-1:0] timeout_eff;
    logic [AGE_WIDTH-1:0]          age_inc;
    ham_pkg::feed_t                first_fd;
    ham_pkg::feed_t                second_fd;

    // apb access
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[ham_pkg::APB_ADDR_W-1:ham_pkg::REG_IDX_LO];

    // register read back
    always_comb
    begin
        prdata = '0;
        case (cfg_idx)
            ham_pkg::REG_ENABLE:     prdata = ham_pkg::APB_DATA_W'(enable_reg);
            ham_pkg::REG_FIRST_HDR:  prdata = ham_pkg::APB_DATA_W'(first_hdr_reg);
            ham_pkg::REG_FIRST_LEN:  prdata = ham_pkg::APB_DATA_W'(first_len_reg);
            ham_pkg::REG_SECOND_HDR: prdata = ham_pkg::APB_DATA_W'(second_hdr_reg);
            ham_pkg::REG_SECOND_LEN: prdata = ham_pkg::APB_DATA_W'(second_len_reg);
            ham_pkg::REG_TIMEOUT:    prdata = ham_pkg::APB_DATA_W'(timeout_reg);
            default:                 prdata = '0;
        endcase
    end

    // configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= ham_pkg::ENABLE_RST;
            first_hdr_reg  <= ham_pkg::HEADER_RST;
            first_len_reg  <= ham_pkg::FIRST_LEN_RST;
            second_hdr_reg <= ham_pkg::HEADER_RST;
            second_len_reg <= ham_pkg::SECOND_LEN_RST;
            timeout_reg    <= ham_pkg::TIMEOUT_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                ham_pkg::REG_ENABLE:     enable_reg     <= pwdata[0];
                ham_pkg::REG_FIRST_HDR:  first_hdr_reg  <= pwdata[ham_pkg::HDR_W-1:0];
                ham_pkg::REG_FIRST_LEN:  first_len_reg  <= pwdata[ham_pkg::LEN_W-1:0];
                ham_pkg::REG_SECOND_HDR: second_hdr_reg <= pwdata[ham_pkg::HDR_W-1:0];
                ham_pkg::REG_SECOND_LEN: second_len_reg <= pwdata[ham_pkg::LEN_W-1:0];
                ham_pkg::REG_TIMEOUT:    timeout_reg    <= pwdata[ham_pkg::TIMEOUT_W-1:0];
                default:                 ;
            endcase
        end
    end

    // handshake: take a request when the output register is free or drains
    assign in_take      = in_ch.valid && in_ch.ready;
    assign in_ch.ready  = !out_valid_reg || out_ch.ready;

    // header matchers, second one only sees bytes the first did not complete
    assign first_fd  = ham_pkg::ham_feed(first_hdr_reg, first_len_reg, first_pos_reg,
                                         in_ch.rx_byte);
    assign second_fd = ham_pkg::ham_feed(second_hdr_reg, second_len_reg, second_pos_reg,
                                         in_ch.rx_byte);

    // effective timeout and saturating age step
    assign timeout_eff = (timeout_reg == '0) ? ham_pkg::TIMEOUT_W'(1) : timeout_reg;
    assign age_inc     = (age_reg != AGE_MAX) ? age_reg + AGE_WIDTH'(1) : age_reg;

    // next state and result for one request
    always_comb
    begin
        first_pos_next  = first_pos_reg;
        second_pos_next = second_pos_reg;
        valid_flag_next = valid_flag_reg;
        age_next        = age_reg;
        hit_next        = 1'b0;
        tev_next        = 1'b0;
        if (in_ch.opcode == ham_pkg::OP_BYTE)
        begin
            if (enable_reg)
            begin
                first_pos_next = first_fd.pos;
                if (first_fd.done)
                begin
                    hit_next = 1'b1;
                end
                else
                begin
                    second_pos_next = second_fd.pos;
                    hit_next        = second_fd.done;
                end
                if (hit_next)
                begin
                    valid_flag_next = 1'b1;
                    age_next        = '0;
                end
            end
        end
        else
        begin
            age_next = age_inc;
            if (!enable_reg)
            begin
                valid_flag_next = 1'b0;
            end
            else if (valid_flag_reg && (CMP_W'(age_inc) >= CMP_W'(timeout_eff)))
            begin
                valid_flag_next = 1'b0;
                tev_next        = 1'b1;
            end
        end
        active_next = enable_reg && valid_flag_next &&
                      (CMP_W'(age_next) < CMP_W'(timeout_eff));
    end

    // monitor state update; an enable write clears flag and age
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_pos_reg  <= '0;
            second_pos_reg <= '0;
            valid_flag_reg <= 1'b0;
            age_reg        <= '0;
        end
        else if (cfg_wr && (cfg_idx == ham_pkg::REG_ENABLE))
        begin
            valid_flag_reg <= 1'b0;
            age_reg        <= '0;
        end
        else if (in_take)
        begin
            first_pos_reg  <= first_pos_next;
            second_pos_reg <= second_pos_next;
            valid_flag_reg <= valid_flag_next;
            age_reg        <= age_next;
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            active_reg <= active_next;
            hit_reg    <= hit_next;
            tev_reg    <= tev_next;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.signal_active = active_reg;
    assign out_ch.header_hit    = hit_reg;
    assign out_ch.timeout_event = tev_reg;

    // a completed header always leaves the signal active
    a_hit_active: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && hit_reg) |-> active_reg)
        else $error("header hit without active signal");

    // a timeout leaves the signal inactive and is never reported with a hit
    a_tev_inactive: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && tev_reg) |-> (!active_reg && !hit_reg))
        else $error("timeout event with active signal or hit");

    // every taken request produces a result in the next cycle
    a_take_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> out_valid_reg)
        else $error("request taken without result");

    // the flag cannot rise on a tick
    a_flag_rise: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && (in_ch.opcode == ham_pkg::OP_TICK)) |=> !$rose(valid_flag_reg))
        else $error("active flag set by a tick");

endmodule
